// File: sv/hvn_pkg.sv
// Shared types, constants and helper functions for the heightmap vertex normal block.
// No dependencies; every other file imports this package.
`default_nettype none

package hvn_pkg;

	localparam int MAX_MAP_SIZE = 256;
	localparam int CW = $clog2(MAX_MAP_SIZE);
	localparam int AW = 2 * CW;
	localparam int DEPTH = MAX_MAP_SIZE * MAX_MAP_SIZE;

	localparam int XW = 8;        // map coordinate field
	localparam int NBW = 9;       // neighbour coordinate, may reach MAX_MAP_SIZE
	localparam int HW = 16;       // height field
	localparam int SCW = 8;       // tile scale
	localparam int SZW = 9;       // map size register
	localparam int CFG_DW = 9;    // widest register
	localparam int NW = 16;       // result component
	localparam int DW = 17;       // difference vector component
	localparam int CPW = 36;      // cross product component, multiplier A operand
	localparam int MBW = 18;      // multiplier B operand
	localparam int PW = CPW + MBW;
	localparam int SUMW = 35;     // sum of eight unit vectors
	localparam int VW = 51;       // unit input component
	localparam int UW = 32;       // unit output component

	localparam int Q_CROSS = 30;
	localparam int Q_FIN = 14;

	localparam logic signed [MBW-1:0] WGT_XY = 18'sd62259;
	localparam logic signed [MBW-1:0] WGT_Z = 18'sd58982;
	localparam logic signed [NW-1:0] NORM_ONE = 16'sd16384;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_NORMAL = 1'b1;

	localparam logic CFG_MAP_SIZE = 1'b0;
	localparam logic CFG_TILE_SCALE = 1'b1;

	localparam logic [SZW-1:0] MAP_SIZE_RST = 9'd256;
	localparam logic [SCW-1:0] TILE_SCALE_RST = 8'd10;

	typedef struct packed {
		logic op;
		logic [XW-1:0] x;
		logic [XW-1:0] y;
		logic signed [HW-1:0] height;
	} hvn_item_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} unit_stat_t;

	typedef enum logic [3:0] {
		B_IDLE, B_BASE, B_BCAP, B_RDA, B_RDB, B_RDH, B_MUL, B_UST, B_UWAIT,
		B_WMUL, B_WST, B_WWAIT, B_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		U_IDLE, U_NORM, U_SQ, U_ROOT, U_DLOAD, U_DIV
	} unit_state_t;

	// ring walk: (-1,-1) (0,-1) (1,-1) (1,0) (1,1) (0,1) (-1,1) (-1,0) and back to start
	function automatic logic signed [1:0] ring_dx(input logic [3:0] k);
		case (k)
			4'd1, 4'd5: ring_dx = 2'sd0;
			4'd2, 4'd3, 4'd4: ring_dx = 2'sd1;
			default: ring_dx = -2'sd1;
		endcase
	endfunction

	function automatic logic signed [1:0] ring_dy(input logic [3:0] k);
		case (k)
			4'd3, 4'd7: ring_dy = 2'sd0;
			4'd4, 4'd5, 4'd6: ring_dy = 2'sd1;
			default: ring_dy = -2'sd1;
		endcase
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [NBW-1:0] x,
			input logic [NBW-1:0] y);
		addr_of = AW'(32'(y) * MAX_MAP_SIZE + 32'(x));
	endfunction

endpackage

`default_nettype wire

// File: sv/hvn_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on hvn_pkg for field widths.
`default_nettype none

interface hvn_in_if import hvn_pkg::*; ();
	logic valid;
	logic ready;
	logic op;
	logic [XW-1:0] map_x;
	logic [XW-1:0] map_y;
	logic signed [HW-1:0] height;

	modport source(output valid, op, map_x, map_y, height, input ready);
	modport sink(input valid, op, map_x, map_y, height, output ready);
endinterface

interface hvn_out_if import hvn_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [NW-1:0] normal_x;
	logic signed [NW-1:0] normal_y;
	logic signed [NW-1:0] normal_z;

	modport source(output valid, normal_x, normal_y, normal_z, input ready);
	modport sink(input valid, normal_x, normal_y, normal_z, output ready);
endinterface

`default_nettype wire

// File: sv/hvn_fifo.sv
// Two-entry item queue between the front and the back.
// Depends on hvn_pkg for the item type.
`default_nettype none

module hvn_fifo import hvn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input hvn_item_t push_item,
	input logic pop,
	output hvn_item_t pop_item,
	output logic full,
	output logic empty
);

	hvn_item_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/hvn_front.sv
// Front: accepts items, reduces normal coordinates modulo the map size, queues them.
// Depends on hvn_pkg and hvn_in_if.
`default_nettype none

module hvn_front import hvn_pkg::*; (
	input logic clk,
	input logic arst_n,
	hvn_in_if.sink in_ch,
	input logic [SZW-1:0] size,
	input logic full,
	output logic push,
	output hvn_item_t push_item
);

	localparam int STEPS = XW;

	logic busy_q;
	logic [$clog2(STEPS+1)-1:0] cnt_q;
	logic [XW-1:0] x_q, y_q;
	logic [SZW-1:0] remx_q, remy_q;
	logic acc, mod_done;

	function automatic logic [SZW-1:0] mod_step(input logic [SZW-1:0] r, input logic b,
			input logic [SZW-1:0] s);
		logic [SZW:0] t;
		t = {r, b};
		if (t >= {1'b0, s}) begin
			t = t - {1'b0, s};
		end
		mod_step = t[SZW-1:0];
	endfunction

	assign in_ch.ready = !busy_q && !full;
	assign acc = in_ch.valid && in_ch.ready;
	assign mod_done = busy_q && (cnt_q == ($clog2(STEPS+1))'(STEPS));
	assign push = (acc && (in_ch.op == OP_WRITE)) || (mod_done && !full);

	always_comb begin
		if (busy_q) begin
			push_item = '{op: OP_NORMAL, x: remx_q[XW-1:0], y: remy_q[XW-1:0], height: '0};
		end else begin
			push_item = '{op: in_ch.op, x: in_ch.map_x, y: in_ch.map_y,
				height: in_ch.height};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_q <= in_ch.map_x;
			y_q <= in_ch.map_y;
			remx_q <= '0;
			remy_q <= '0;
		end else if (busy_q && !mod_done) begin
			// one remainder bit per cycle, most significant first
			remx_q <= mod_step(remx_q, x_q[XW-1], size);
			remy_q <= mod_step(remy_q, y_q[XW-1], size);
			x_q <= x_q << 1;
			y_q <= y_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (acc) begin
			busy_q <= (in_ch.op == OP_NORMAL);
			cnt_q <= '0;
		end else if (busy_q) begin
			if (!mod_done) begin
				cnt_q <= cnt_q + ($clog2(STEPS+1))'(1);
			end else if (!full) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/hvn_unit.sv
// Shared unit-vector unit: normalise, sum of squares, integer root, three divides.
// Depends on hvn_pkg.
`default_nettype none

module hvn_unit import hvn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic fin,
	input logic signed [VW-1:0] c0,
	input logic signed [VW-1:0] c1,
	input logic signed [VW-1:0] c2,
	output unit_stat_t stat,
	output logic signed [UW-1:0] u0,
	output logic signed [UW-1:0] u1,
	output logic signed [UW-1:0] u2
);

	unit_state_t state_q, state_d;
	logic [VW-1:0] m_q [3];
	logic neg_q [3];
	logic signed [UW-1:0] u_q [3];
	logic [VW-1:0] big_q;
	logic [63:0] n2_q, res_q, bit_q, num_q;
	logic [61:0] sq_q;
	logic [1:0] i_q;
	logic [31:0] r_q, rem_q, quo_q;
	logic [4:0] cnt_q;
	logic fin_q, done_q, zero_q;

	logic [VW-1:0] mag [3];
	logic [VW-1:0] big_in;
	logic [63:0] rb, nq;
	logic [32:0] t;
	logic ge, last;
	logic [31:0] nquo;

	always_comb begin
		mag[0] = c0[VW-1] ? VW'(-c0) : VW'(c0);
		mag[1] = c1[VW-1] ? VW'(-c1) : VW'(c1);
		mag[2] = c2[VW-1] ? VW'(-c2) : VW'(c2);
		big_in = mag[0];
		if (mag[1] > big_in) big_in = mag[1];
		if (mag[2] > big_in) big_in = mag[2];
		rb = res_q + bit_q;
		nq = fin_q ? (64'(m_q[i_q][30:0]) << Q_FIN) + 64'(res_q[31:0] >> 1)
			: (64'(m_q[i_q][30:0]) << Q_CROSS) + 64'(res_q[31:0] >> 1);
		t = {rem_q, num_q[63]};
		ge = (t >= {1'b0, r_q});
		nquo = {quo_q[30:0], ge};
		last = fin_q ? (cnt_q == 5'(Q_FIN)) : (cnt_q == 5'(Q_CROSS));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE: if (start && big_in != '0) state_d = U_NORM;
			U_NORM: if (big_q[VW-1:31] == '0 && big_q[30]) state_d = U_SQ;
			U_SQ: if (i_q == 2'd3) state_d = U_ROOT;
			U_ROOT: if (bit_q[0]) state_d = U_DLOAD;
			U_DLOAD: state_d = U_DIV;
			U_DIV: begin
				if (last) state_d = (i_q == 2'd2) ? U_IDLE : U_DLOAD;
			end
			default: state_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (start) begin
					m_q[0] <= mag[0];
					m_q[1] <= mag[1];
					m_q[2] <= mag[2];
					neg_q[0] <= c0[VW-1];
					neg_q[1] <= c1[VW-1];
					neg_q[2] <= c2[VW-1];
					big_q <= big_in;
					fin_q <= fin;
					i_q <= 2'd0;
					n2_q <= '0;
				end
			end
			U_NORM: begin
				// bring the largest magnitude into [2^30, 2^31)
				if (big_q[VW-1:31] != '0) begin
					big_q <= big_q >> 1;
					m_q[0] <= m_q[0] >> 1;
					m_q[1] <= m_q[1] >> 1;
					m_q[2] <= m_q[2] >> 1;
				end else if (!big_q[30]) begin
					big_q <= big_q << 1;
					m_q[0] <= m_q[0] << 1;
					m_q[1] <= m_q[1] << 1;
					m_q[2] <= m_q[2] << 1;
				end
			end
			U_SQ: begin
				if (i_q != 2'd3) sq_q <= m_q[i_q][30:0] * m_q[i_q][30:0];
				if (i_q != 2'd0) n2_q <= n2_q + 64'(sq_q);
				if (i_q == 2'd3) begin
					i_q <= 2'd0;
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end else begin
					i_q <= i_q + 2'd1;
				end
			end
			U_ROOT: begin
				if (n2_q >= rb) begin
					n2_q <= n2_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			U_DLOAD: begin
				if (i_q == 2'd0) r_q <= res_q[31:0];
				num_q <= fin_q ? (nq << (63 - Q_FIN)) : (nq << (63 - Q_CROSS));
				rem_q <= fin_q ? 32'(nq >> (Q_FIN + 1)) : 32'(nq >> (Q_CROSS + 1));
				quo_q <= '0;
				cnt_q <= '0;
			end
			U_DIV: begin
				rem_q <= ge ? 32'(t - {1'b0, r_q}) : t[31:0];
				num_q <= num_q << 1;
				quo_q <= nquo;
				cnt_q <= cnt_q + 5'd1;
				if (last) begin
					u_q[i_q] <= neg_q[i_q] ? -$signed(nquo) : $signed(nquo);
					i_q <= i_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	// the root is taken from res_q on the first divide load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= ((state_q == U_IDLE) && start && big_in == '0)
				|| ((state_q == U_DIV) && last && i_q == 2'd2);
			if (state_q == U_IDLE && start) zero_q <= (big_in == '0);
		end
	end

	assign stat = '{busy: (state_q != U_IDLE), done: done_q, zero: zero_q};
	assign u0 = u_q[0];
	assign u1 = u_q[1];
	assign u2 = u_q[2];

	a_rem_below_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == U_DIV) |-> (rem_q < r_q))
		else $error("divide remainder not below root");
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !zero_q) |-> (r_q != '0))
		else $error("unit vector finished with zero root");

endmodule

`default_nettype wire

// File: sv/hvn_back.sv
// Back: height store, ring walk, cross products, accumulation and result register.
// Depends on hvn_pkg, hvn_out_if and hvn_unit.
`default_nettype none

module hvn_back import hvn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input hvn_item_t item,
	output logic pop,
	input logic [SZW-1:0] size,
	input logic [SCW-1:0] scale,
	hvn_out_if.source out_ch
);

	back_state_t state_q, state_d;
	logic signed [HW-1:0] mem [DEPTH];
	logic signed [HW-1:0] rd_q, hbase_q, ha_q;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [XW-1:0] mx_q, my_q;
	logic [2:0] k_q;
	logic [3:0] j_q;
	logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, d1z_q, d2z_q;
	logic signed [CPW-1:0] c0_q, c1_q, c2_q;
	logic signed [PW-1:0] prod_q;
	logic signed [CPW-1:0] ma;
	logic signed [MBW-1:0] mb;
	logic signed [SUMW-1:0] s0_q, s1_q, s2_q;
	logic signed [VW-1:0] w0_q, w1_q, w2_q;
	logic signed [NW-1:0] nx_q, ny_q, nz_q, ox_q, oy_q, oz_q;
	logic out_vq, load, ustart, fin;
	unit_stat_t ustat;
	logic signed [UW-1:0] u0, u1, u2;

	logic signed [9:0] ta_x, ta_y, tb_x, tb_y, sz_s, dif_ax, dif_ay, dif_bx, dif_by;
	logic [NBW-1:0] ax, ay, bx, by;
	logic [3:0] kk;

	function automatic logic [NBW-1:0] clamp_c(input logic signed [9:0] v,
			input logic signed [9:0] s);
		if (v < 0) clamp_c = '0;
		else if (v >= s) clamp_c = NBW'(s - 10'sd1);
		else clamp_c = v[NBW-1:0];
	endfunction

	function automatic logic [NBW-1:0] wrap_c(input logic signed [9:0] v,
			input logic signed [9:0] s);
		if (v < 0) wrap_c = NBW'(v + s);
		else if (v >= s) wrap_c = NBW'(v - s);
		else wrap_c = v[NBW-1:0];
	endfunction

	always_comb begin
		kk = {1'b0, k_q};
		sz_s = $signed({1'b0, size});
		ta_x = $signed({2'b00, mx_q}) + 10'(ring_dx(kk));
		ta_y = $signed({2'b00, my_q}) + 10'(ring_dy(kk));
		tb_x = $signed({2'b00, mx_q}) + 10'(ring_dx(kk + 4'd1));
		tb_y = $signed({2'b00, my_q}) + 10'(ring_dy(kk + 4'd1));
		ax = clamp_c(ta_x, sz_s);
		ay = clamp_c(ta_y, sz_s);
		bx = wrap_c(tb_x, sz_s);
		by = wrap_c(tb_y, sz_s);
		dif_ax = $signed({2'b00, mx_q}) - $signed({1'b0, ax});
		dif_ay = $signed({2'b00, my_q}) - $signed({1'b0, ay});
		dif_bx = $signed({2'b00, mx_q}) - $signed({1'b0, bx});
		dif_by = $signed({2'b00, my_q}) - $signed({1'b0, by});
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = $signed({{(MBW-SCW){1'b0}}, scale});
		if (state_q == B_WMUL) begin
			case (j_q)
				4'd0: begin ma = CPW'(s0_q); mb = WGT_XY; end
				4'd1: begin ma = CPW'(s1_q); mb = WGT_XY; end
				default: begin ma = CPW'(s2_q); mb = WGT_Z; end
			endcase
		end else begin
			case (j_q)
				4'd0: ma = CPW'(dif_ax);
				4'd1: ma = CPW'(dif_ay);
				4'd2: ma = CPW'(dif_bx);
				4'd3: ma = CPW'(dif_by);
				4'd4: begin ma = CPW'(d1y_q); mb = MBW'(d2z_q); end
				4'd5: begin ma = CPW'(d1z_q); mb = MBW'(d2y_q); end
				4'd6: begin ma = CPW'(d1z_q); mb = MBW'(d2x_q); end
				4'd7: begin ma = CPW'(d1x_q); mb = MBW'(d2z_q); end
				4'd8: begin ma = CPW'(d1x_q); mb = MBW'(d2y_q); end
				4'd9: begin ma = CPW'(d1y_q); mb = MBW'(d2x_q); end
				default: ma = '0;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		wr_en = 1'b0;
		ustart = 1'b0;
		fin = 1'b0;
		load = 1'b0;
		rd_addr = addr_of(NBW'(mx_q), NBW'(my_q));
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (item.op == OP_WRITE) begin
						wr_en = (32'(item.x) < MAX_MAP_SIZE) && (32'(item.y) < MAX_MAP_SIZE);
					end else begin
						state_d = B_BASE;
					end
				end
			end
			B_BASE: state_d = B_BCAP;
			B_BCAP: state_d = B_RDA;
			B_RDA: begin
				rd_addr = addr_of(ax, ay);
				state_d = B_RDB;
			end
			B_RDB: begin
				rd_addr = addr_of(bx, by);
				state_d = B_RDH;
			end
			B_RDH: state_d = B_MUL;
			B_MUL: if (j_q == 4'd10) state_d = B_UST;
			B_UST: begin
				ustart = 1'b1;
				state_d = B_UWAIT;
			end
			B_UWAIT: begin
				if (ustat.done) state_d = (k_q == 3'd7) ? B_WMUL : B_RDA;
			end
			B_WMUL: if (j_q == 4'd3) state_d = B_WST;
			B_WST: begin
				ustart = 1'b1;
				fin = 1'b1;
				state_d = B_WWAIT;
			end
			B_WWAIT: if (ustat.done) state_d = B_OUT;
			B_OUT: begin
				if (!out_vq || out_ch.ready) begin
					load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[addr_of(NBW'(item.x), NBW'(item.y))] <= item.height;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (state_q)
			B_IDLE: begin
				mx_q <= item.x;
				my_q <= item.y;
			end
			B_BCAP: begin
				hbase_q <= rd_q;
				k_q <= 3'd0;
				s0_q <= '0;
				s1_q <= '0;
				s2_q <= '0;
			end
			B_RDB: ha_q <= rd_q;
			B_RDH: begin
				d1z_q <= DW'(hbase_q) - DW'(ha_q);
				d2z_q <= DW'(hbase_q) - DW'(rd_q);
				j_q <= 4'd0;
			end
			B_MUL: begin
				j_q <= j_q + 4'd1;
				// product of the previous step lands here
				case (j_q)
					4'd1: d1x_q <= DW'(prod_q);
					4'd2: d1y_q <= DW'(prod_q);
					4'd3: d2x_q <= DW'(prod_q);
					4'd4: d2y_q <= DW'(prod_q);
					4'd5: c0_q <= CPW'(prod_q);
					4'd6: c0_q <= c0_q - CPW'(prod_q);
					4'd7: c1_q <= CPW'(prod_q);
					4'd8: c1_q <= c1_q - CPW'(prod_q);
					4'd9: c2_q <= CPW'(prod_q);
					4'd10: c2_q <= c2_q - CPW'(prod_q);
					default: ;
				endcase
			end
			B_UWAIT: begin
				if (ustat.done) begin
					// flip downward-facing normals before adding
					if (!ustat.zero) begin
						if (u2 < 0) begin
							s0_q <= s0_q - SUMW'(u0);
							s1_q <= s1_q - SUMW'(u1);
							s2_q <= s2_q - SUMW'(u2);
						end else begin
							s0_q <= s0_q + SUMW'(u0);
							s1_q <= s1_q + SUMW'(u1);
							s2_q <= s2_q + SUMW'(u2);
						end
					end
					k_q <= k_q + 3'd1;
					j_q <= 4'd0;
				end
			end
			B_WMUL: begin
				j_q <= j_q + 4'd1;
				case (j_q)
					4'd1: w0_q <= VW'(prod_q);
					4'd2: w1_q <= VW'(prod_q);
					4'd3: w2_q <= VW'(prod_q);
					default: ;
				endcase
			end
			B_WWAIT: begin
				if (ustat.done) begin
					if (ustat.zero) begin
						nx_q <= '0;
						ny_q <= '0;
						nz_q <= NORM_ONE;
					end else begin
						nx_q <= u0[NW-1:0];
						ny_q <= u1[NW-1:0];
						nz_q <= u2[NW-1:0];
					end
				end
			end
			default: ;
		endcase
		if (load) begin
			ox_q <= nx_q;
			oy_q <= ny_q;
			oz_q <= nz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_vq <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) out_vq <= 1'b1;
			else if (out_ch.ready) out_vq <= 1'b0;
		end
	end

	assign out_ch.valid = out_vq;
	assign out_ch.normal_x = ox_q;
	assign out_ch.normal_y = oy_q;
	assign out_ch.normal_z = oz_q;

	hvn_unit u_unit (
		.clk(clk),
		.arst_n(arst_n),
		.start(ustart),
		.fin(fin),
		.c0(fin ? w0_q : VW'(c0_q)),
		.c1(fin ? w1_q : VW'(c1_q)),
		.c2(fin ? w2_q : VW'(c2_q)),
		.stat(ustat),
		.u0(u0),
		.u1(u1),
		.u2(u2)
	);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ustart |-> !ustat.busy)
		else $error("unit started while busy");
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		ustat.done |-> (state_q == B_UWAIT || state_q == B_WWAIT))
		else $error("unit result with nobody waiting");
	a_weight_after_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WMUL) |-> ((j_q != 4'd0) || (k_q == 3'd0 && $past(k_q) == 3'd7)))
		else $error("weighting before the ring walk ended");

endmodule

`default_nettype wire

// File: sv/heightmap_vertex_normal.sv
// Heightmap vertex normal block: top level with configuration registers.
// Depends on hvn_pkg, hvn_if, hvn_front, hvn_fifo, hvn_back (and hvn_unit below it).
//
// Input items arrive on in_ch (valid/ready). op = write stores one height at
// (map_x, map_y) and gives no result. op = normal gives one result on out_ch:
// the averaged unit normal of the cell in Q1.14.
// The front reduces the coordinates modulo the map size and queues
// the item (two-entry queue); a write is queued in its accept cycle.
// The back retires a write in the cycle it pops it. A normal takes eight ring
// steps, each with two store reads, the multiplier steps for the difference
// vectors and the cross product and one pass of the shared unit-vector unit
// (normalising shift, sum of squares, 32-step root, three bit-serial divides;
// a zero cross product ends the pass at once), then a weighting pass and a
// final, shorter pass of the same shared unit-vector unit.
// Results sit in an output register; while out_ch stalls, the back keeps
// working on queued items and waits only when its next result is ready.
// Reset sets map_size to 256 and tile_scale to 10 and empties all control
// state; the height store is not cleared and a cell must be written before
// it is read. Configuration is written through cfg_wr_en/cfg_index/cfg_data
// while the block is idle.
`default_nettype none

module heightmap_vertex_normal import hvn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_index,
	input logic [CFG_DW-1:0] cfg_data,
	hvn_in_if.sink in_ch,
	hvn_out_if.source out_ch
);

	logic [SZW-1:0] map_size_q, size;
	logic [SCW-1:0] tile_scale_q;
	logic push, pop, full, empty;
	hvn_item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q <= MAP_SIZE_RST;
			tile_scale_q <= TILE_SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MAP_SIZE: map_size_q <= cfg_data[SZW-1:0];
				CFG_TILE_SCALE: tile_scale_q <= cfg_data[SCW-1:0];
				default: ;
			endcase
		end
	end

	// saturate the map size to 2..MAX_MAP_SIZE
	always_comb begin
		if (map_size_q < 9'd2) size = 9'd2;
		else if (32'(map_size_q) > MAX_MAP_SIZE) size = SZW'(MAX_MAP_SIZE);
		else size = map_size_q;
	end

	hvn_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.size(size),
		.full(full),
		.push(push),
		.push_item(push_item)
	);

	hvn_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.pop_item(pop_item),
		.full(full),
		.empty(empty)
	);

	hvn_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.item(pop_item),
		.pop(pop),
		.size(size),
		.scale(tile_scale_q),
		.out_ch(out_ch)
	);

endmodule

`default_nettype wire

// File: tb/sv/hvn_normal_checker.sv
`timescale 1ns / 100ps
// Checker for the heightmap vertex normal block: keeps its own height store
// and registers, predicts each normal and compares it. Depends on hvn_pkg, hvn_if.
`default_nettype none

module hvn_normal_checker import hvn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_index,
	input logic [CFG_DW-1:0] cfg_data,
	hvn_in_if in_ch,
	hvn_out_if out_ch,
	output int errors,
	output int pending
);

	typedef longint vec3_t [3];
	typedef struct {
		logic signed [NW-1:0] x;
		logic signed [NW-1:0] y;
		logic signed [NW-1:0] z;
	} normal_t;

	logic signed [HW-1:0] heights [DEPTH];
	logic [SZW-1:0] size_reg;
	logic [SCW-1:0] scale_reg;
	normal_t normals_due [$];

	assign pending = normals_due.size();

	function automatic longint unsigned isqrt(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// scale to unit length with q fraction bits; zero vector gives 0
	function automatic bit make_unit(input vec3_t c, input int q, output vec3_t u);
		longint unsigned m [3];
		longint unsigned big, n2, r, v;
		big = 0;
		n2 = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
			if (m[i] > big) big = m[i];
		end
		if (big == 0) return 0;
		while (big >= (64'd1 << 31)) begin
			big >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (big < (64'd1 << 30)) begin
			big <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) n2 += m[i] * m[i];
		r = isqrt(n2);
		for (int i = 0; i < 3; i++) begin
			v = ((m[i] << q) + r / 2) / r;
			u[i] = c[i] < 0 ? -longint'(v) : longint'(v);
		end
		return 1;
	endfunction

	function automatic longint height_at(input int x, input int y);
		return longint'(heights[y * MAX_MAP_SIZE + x]);
	endfunction

	function automatic normal_t face_normal(input int raw_x, input int raw_y);
		int ring_x [9] = '{-1, 0, 1, 1, 1, 0, -1, -1, -1};
		int ring_y [9] = '{-1, -1, -1, 0, 1, 1, 1, 0, -1};
		int size, scale, mx, my, ax, ay, bx, by;
		vec3_t base, acc, d1, d2, c, u, w, res;
		normal_t n;
		size = int'(size_reg);
		if (size < 2) size = 2;
		if (size > MAX_MAP_SIZE) size = MAX_MAP_SIZE;
		scale = int'(scale_reg);
		mx = raw_x % size;
		my = raw_y % size;
		base[0] = longint'(mx * scale);
		base[1] = longint'(my * scale);
		base[2] = height_at(mx, my);
		acc = '{0, 0, 0};
		for (int k = 0; k < 8; k++) begin
			ax = mx + ring_x[k];
			ay = my + ring_y[k];
			bx = mx + ring_x[k + 1];
			by = my + ring_y[k + 1];
			// first of the pair clamps, second wraps
			if (ax < 0) ax = 0; else if (ax >= size) ax = size - 1;
			if (ay < 0) ay = 0; else if (ay >= size) ay = size - 1;
			if (bx < 0) bx += size; else if (bx >= size) bx -= size;
			if (by < 0) by += size; else if (by >= size) by -= size;
			d1[0] = base[0] - longint'(ax * scale);
			d1[1] = base[1] - longint'(ay * scale);
			d1[2] = base[2] - height_at(ax, ay);
			d2[0] = base[0] - longint'(bx * scale);
			d2[1] = base[1] - longint'(by * scale);
			d2[2] = base[2] - height_at(bx, by);
			c[0] = d1[1] * d2[2] - d1[2] * d2[1];
			c[1] = d1[2] * d2[0] - d1[0] * d2[2];
			c[2] = d1[0] * d2[1] - d1[1] * d2[0];
			if (make_unit(c, Q_CROSS, u))
				for (int i = 0; i < 3; i++)
					acc[i] = u[2] < 0 ? acc[i] - u[i] : acc[i] + u[i];
		end
		w[0] = acc[0] * longint'(WGT_XY);
		w[1] = acc[1] * longint'(WGT_XY);
		w[2] = acc[2] * longint'(WGT_Z);
		if (!make_unit(w, Q_FIN, res)) res = '{0, 0, longint'(NORM_ONE)};
		n.x = res[0][NW-1:0];
		n.y = res[1][NW-1:0];
		n.z = res[2][NW-1:0];
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg <= MAP_SIZE_RST;
			scale_reg <= TILE_SCALE_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_MAP_SIZE)
				size_reg <= cfg_data[SZW-1:0];
			else
				scale_reg <= cfg_data[SCW-1:0];
		end
	end

	initial errors = 0;

	always @(posedge clk) begin
		normal_t got, want;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (in_ch.op == OP_WRITE)
				heights[int'(in_ch.map_y) * MAX_MAP_SIZE + int'(in_ch.map_x)] = in_ch.height;
			else
				normals_due.push_back(face_normal(int'(in_ch.map_x), int'(in_ch.map_y)));
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.x = out_ch.normal_x;
			got.y = out_ch.normal_y;
			got.z = out_ch.normal_z;
			if (normals_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected normal (%0d, %0d, %0d)", got.x, got.y, got.z);
			end else begin
				want = normals_due.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
					errors++;
					if (errors <= 10)
						$display("normal mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
							want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the heightmap vertex normal testbench: clock, reset, stimulus and verdict.
// Depends on hvn_pkg, hvn_if, hvn_normal_checker and the block itself.
`default_nettype none

module tb import hvn_pkg::*;;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	int errors, pending;
	int idle_cycles = 0;
	int stall_left = 0;
	bit calm = 0;
	bit written [DEPTH];
	int cur_size = MAX_MAP_SIZE;

	hvn_in_if in_ch ();
	hvn_out_if out_ch ();

	heightmap_vertex_normal u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	hvn_normal_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
		.errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side stalls in bursts
	always @(negedge clk) begin
		if (!calm && stall_left == 0 && $urandom_range(0, 15) == 0)
			stall_left = $urandom_range(1, 17);
		if (stall_left > 0) begin
			out_ch.ready = 1'b0;
			stall_left--;
		end else
			out_ch.ready = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic send(input logic op, input int x, input int y, input logic [HW-1:0] h);
		if (!calm && $urandom_range(0, 15) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_ch.op = op;
		in_ch.map_x = x[XW-1:0];
		in_ch.map_y = y[XW-1:0];
		in_ch.height = h;
		in_ch.valid = 1'b1;
		if (op == OP_WRITE) written[y * MAX_MAP_SIZE + x] = 1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_reg(input logic idx, input int value);
		drain();
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = value[CFG_DW-1:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == CFG_MAP_SIZE)
			cur_size = value % 512 < 2 ? 2 : (value % 512 > MAX_MAP_SIZE ? MAX_MAP_SIZE : value % 512);
	endtask

	function automatic logic [HW-1:0] rand_height();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return HW'($urandom());
		endcase
	endfunction

	// fill every cell the ring may read before asking for the normal
	task automatic normal_at(input int x, input int y);
		int rx, ry, cx, cy;
		rx = x % cur_size;
		ry = y % cur_size;
		for (int a = -1; a <= 1; a++)
			for (int b = -1; b <= 1; b++)
				for (int v = 0; v < 4; v++) begin
					cx = rx + a;
					cy = ry + b;
					if (v[0]) cx = (cx + cur_size) % cur_size;
					else cx = cx < 0 ? 0 : (cx >= cur_size ? cur_size - 1 : cx);
					if (v[1]) cy = (cy + cur_size) % cur_size;
					else cy = cy < 0 ? 0 : (cy >= cur_size ? cur_size - 1 : cy);
					if (!written[cy * MAX_MAP_SIZE + cx]) send(OP_WRITE, cx, cy, rand_height());
				end
		send(OP_NORMAL, x, y, HW'($urandom()));
	endtask

	initial begin
		int sizes [8] = '{2, 256, 0, 5, 511, 3, 17, 256};
		int scales [8] = '{1, 255, 0, 7, 3, 200, 37, 1};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_MAP_SIZE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_WRITE;
		in_ch.map_x = '0;
		in_ch.map_y = '0;
		in_ch.height = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// steep corners at the default registers
		send(OP_WRITE, 0, 0, 16'h7fff);
		send(OP_WRITE, 1, 0, 16'h8000);
		send(OP_WRITE, 0, 1, 16'h8000);
		send(OP_WRITE, 1, 1, 16'h7fff);
		send(OP_WRITE, 255, 255, 16'h8000);
		normal_at(0, 0);
		normal_at(255, 255);
		normal_at(0, 255);
		normal_at(170, 85);
		// flat ground with zero scale: every cross product vanishes
		set_reg(CFG_MAP_SIZE, 2);
		set_reg(CFG_TILE_SCALE, 0);
		for (int i = 0; i < 4; i++) send(OP_WRITE, i % 2, i / 2, 16'd5);
		normal_at(1, 1);
		normal_at(254, 3);

		for (int p = 0; p < 8; p++) begin
			set_reg(CFG_MAP_SIZE, sizes[p]);
			set_reg(CFG_TILE_SCALE, scales[p]);
			if (p == 7) calm = 1;
			for (int n = 0; n < 56; n++) begin
				if ($urandom_range(0, 99) < 30)
					normal_at($urandom_range(0, 255), $urandom_range(0, 255));
				else if ($urandom_range(0, 1) == 0)
					send(OP_WRITE, $urandom_range(0, cur_size - 1),
						$urandom_range(0, cur_size - 1), rand_height());
				else
					send(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
						rand_height());
			end
		end

		drain();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
sv/hvn_pkg.sv
sv/hvn_if.sv
sv/hvn_fifo.sv
sv/hvn_front.sv
sv/hvn_unit.sv
sv/hvn_back.sv
sv/heightmap_vertex_normal.sv
tb/sv/hvn_normal_checker.sv
tb/sv/tb.sv
